// ===== design/bms_pkg.sv =====
`default_nettype none
package bms_pkg;

  // input opcodes
  localparam logic [1:0] OP_TICK    = 2'd0;
  localparam logic [1:0] OP_REQUEST = 2'd1;
  localparam logic [1:0] OP_DONE    = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_INTERVAL = 2'd0;
  localparam logic [1:0] CFG_OVERRIDE = 2'd1;
  localparam logic [1:0] CFG_LOW      = 2'd2;
  localparam logic [1:0] CFG_CRIT     = 2'd3;

  // pack formats
  localparam logic [1:0] FMT_UNKNOWN  = 2'd0;
  localparam logic [1:0] FMT_MINI     = 2'd1;
  localparam logic [1:0] FMT_STANDARD = 2'd2;

  // event codes
  localparam logic [2:0] EV_NONE     = 3'd0;
  localparam logic [2:0] EV_ERROR    = 3'd1;
  localparam logic [2:0] EV_CRITICAL = 3'd2;
  localparam logic [2:0] EV_LOW      = 3'd3;
  localparam logic [2:0] EV_UPDATE   = 3'd4;

  // width of the converted voltage before range check
  localparam int MV_CALC_W = 17;

  // valid ranges per format
  localparam logic [MV_CALC_W-1:0] STD_MIN_MV  = 17'd3800;
  localparam logic [MV_CALC_W-1:0] STD_MAX_MV  = 17'd7000;
  localparam logic [MV_CALC_W-1:0] MINI_MIN_MV = 17'd1800;
  localparam logic [MV_CALC_W-1:0] MINI_MAX_MV = 17'd3800;

  // default thresholds
  localparam logic [14:0] STD_LOW_MV   = 15'd4800;
  localparam logic [14:0] STD_CRIT_MV  = 15'd4000;
  localparam logic [14:0] MINI_LOW_MV  = 15'd2400;
  localparam logic [14:0] MINI_CRIT_MV = 15'd2000;

  // charge level: (v - base) / 10 or / 20 through a reciprocal
  localparam logic [14:0] STD_BASE_MV  = 15'd4000;
  localparam logic [14:0] MINI_BASE_MV = 15'd2000;
  localparam logic [15:0] PCT_RECIP    = 16'd52429;
  localparam int          PCT_SH_MINI  = 19;
  localparam int          PCT_SH_STD   = 20;
  localparam logic [6:0]  CHARGE_MAX   = 7'd100;

  typedef enum logic [2:0] {
    PH_PRESENCE = 3'd0,
    PH_DETECT   = 3'd1,
    PH_START    = 3'd2,
    PH_READ     = 3'd3
  } phase_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic        present_pin;
    logic [11:0] adc_millivolts;
    logic        adc_ok;
  } item_t;

  typedef struct packed {
    logic [31:0] interval;
    logic        override;
    logic [14:0] low_mv;
    logic [14:0] crit_mv;
  } cfg_t;

  typedef struct packed {
    phase_t      phase;
    logic [1:0]  fmt;
    logic        measuring;
    logic [14:0] bmv;
    logic        bvalid;
    logic [31:0] countdown;
    logic        armed;
    logic        awaiting;
  } state_t;

  localparam state_t STATE_RESET = '{
    phase:     PH_PRESENCE,
    fmt:       FMT_UNKNOWN,
    measuring: 1'b0,
    bmv:       15'd0,
    bvalid:    1'b0,
    countdown: 32'd0,
    armed:     1'b0,
    awaiting:  1'b0
  };

  // what one item produced, before the charge level is added
  typedef struct packed {
    logic [2:0]  ev_a;
    logic [2:0]  ev_b;
    logic        two;
    logic        conv;
    logic        accepted;
    logic [14:0] bmv;
    logic        bvalid;
    logic [1:0]  fmt;
    logic        awaiting;
  } res_t;

  typedef struct packed {
    res_t       res;
    logic [6:0] pct;
  } out_t;

endpackage
`default_nettype wire

// ===== design/bms_in_if.sv =====
`default_nettype none
interface bms_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic        present_pin;
  logic [11:0] adc_millivolts;
  logic        adc_ok;

  modport source (output valid, output opcode, output present_pin,
                  output adc_millivolts, output adc_ok, input ready);
  modport sink   (input valid, input opcode, input present_pin,
                  input adc_millivolts, input adc_ok, output ready);
endinterface
`default_nettype wire

// ===== design/bms_out_if.sv =====
`default_nettype none
interface bms_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_code;
  logic [14:0] voltage_mv;
  logic        voltage_valid;
  logic [6:0]  charge_percent;
  logic [1:0]  battery_format;
  logic        start_conversion;
  logic        sense_enable;
  logic        request_accepted;
  logic        last;

  modport source (output valid, output event_code, output voltage_mv,
                  output voltage_valid, output charge_percent, output battery_format,
                  output start_conversion, output sense_enable,
                  output request_accepted, output last, input ready);
  modport sink   (input valid, input event_code, input voltage_mv,
                  input voltage_valid, input charge_percent, input battery_format,
                  input start_conversion, input sense_enable,
                  input request_accepted, input last, output ready);
endinterface
`default_nettype wire

// ===== design/bms_step.sv =====
`default_nettype none
module bms_step #(
  parameter int COEFF_FRACTION_BITS = 16
) (
  input  bms_pkg::item_t  item,
  input  bms_pkg::state_t st,
  input  bms_pkg::cfg_t   cfg,
  output bms_pkg::state_t st_nxt,
  output bms_pkg::res_t   res
);

  localparam int F     = COEFF_FRACTION_BITS;
  localparam int GainW = F + 4;
  localparam int SumW  = F + 17;
  localparam longint unsigned StdGain    = ((64'd11068 << F) + 64'd650) / 64'd1300;
  localparam longint unsigned StdOffset  = ((64'd212 << F) + 64'd5) / 64'd10;
  localparam longint unsigned MiniGain   = ((64'd3285 << F) + 64'd500) / 64'd1000;
  localparam longint unsigned MiniOffset = ((64'd69 << F) + 64'd5) / 64'd10;
  localparam longint unsigned HalfQ      = 64'd1 << (F - 1);

  logic                            mini;
  logic [GainW-1:0]                gain;
  logic [SumW-1:0]                 offset;
  logic [SumW-1:0]                 sum;
  logic [bms_pkg::MV_CALC_W-1:0]   v;
  logic                            detect_std;
  logic                            read_ok;
  logic [14:0]                     low_mv;
  logic [14:0]                     crit_mv;
  logic                            interval_nz;
  logic [31:0]                     cd_dec;
  logic                            run;
  bms_pkg::state_t                 n;
  logic [2:0]                      ev_a;
  logic [2:0]                      ev_b;
  logic                            two;
  logic                            conv;
  logic                            accepted;

  // detection always uses the standard coefficients
  assign mini   = (st.phase == bms_pkg::PH_READ) && (st.fmt == bms_pkg::FMT_MINI);
  assign gain   = mini ? GainW'(MiniGain) : GainW'(StdGain);
  assign offset = mini ? SumW'(MiniOffset) : SumW'(StdOffset);
  assign sum    = SumW'(item.adc_millivolts) * SumW'(gain) + offset + SumW'(HalfQ);
  assign v      = sum[F +: bms_pkg::MV_CALC_W];

  assign detect_std = item.adc_ok && (v > bms_pkg::STD_MIN_MV) && (v < bms_pkg::STD_MAX_MV);
  assign read_ok = item.adc_ok &&
                   (v >= (mini ? bms_pkg::MINI_MIN_MV : bms_pkg::STD_MIN_MV)) &&
                   (v <= (mini ? bms_pkg::MINI_MAX_MV : bms_pkg::STD_MAX_MV));

  assign low_mv  = cfg.override ? cfg.low_mv :
                   (mini ? bms_pkg::MINI_LOW_MV : bms_pkg::STD_LOW_MV);
  assign crit_mv = cfg.override ? cfg.crit_mv :
                   (mini ? bms_pkg::MINI_CRIT_MV : bms_pkg::STD_CRIT_MV);

  assign interval_nz = (cfg.interval != 32'd0);
  assign cd_dec      = (st.countdown != 32'd0) ? st.countdown - 32'd1 : st.countdown;

  always_comb begin
    n        = st;
    ev_a     = bms_pkg::EV_NONE;
    ev_b     = bms_pkg::EV_NONE;
    two      = 1'b0;
    conv     = 1'b0;
    accepted = 1'b0;
    run      = 1'b0;

    unique case (item.opcode)
      bms_pkg::OP_TICK: begin
        n.countdown = cd_dec;
        if (st.armed && cd_dec == 32'd0) begin
          n.armed = 1'b0;
          run     = 1'b1;
        end
      end
      bms_pkg::OP_REQUEST: begin
        if (!st.measuring) begin
          n.measuring = 1'b1;
          accepted    = 1'b1;
          if (!st.awaiting) begin
            n.armed = 1'b0;
            run     = 1'b1;
          end
        end
      end
      bms_pkg::OP_DONE: begin
        if (st.awaiting) begin
          n.awaiting = 1'b0;
          run        = 1'b1;
        end
      end
      default: begin
      end
    endcase

    if (run) begin
      unique case (st.phase)
        bms_pkg::PH_PRESENCE: begin
          n.countdown = cfg.interval;
          n.fmt       = bms_pkg::FMT_UNKNOWN;
          if (!item.present_pin) begin
            n.armed = interval_nz;
            if (!interval_nz) n.measuring = 1'b0;
            ev_a = bms_pkg::EV_ERROR;
          end else begin
            n.awaiting = 1'b1;
            conv       = 1'b1;
            n.phase    = bms_pkg::PH_DETECT;
          end
        end
        bms_pkg::PH_DETECT: begin
          n.fmt = detect_std ? bms_pkg::FMT_STANDARD : bms_pkg::FMT_MINI;
          // a pending measurement goes straight on to its start
          if (n.measuring) begin
            n.countdown = cfg.interval;
            n.awaiting  = 1'b1;
            conv        = 1'b1;
            n.phase     = bms_pkg::PH_READ;
          end else begin
            n.phase = bms_pkg::PH_START;
            n.armed = interval_nz;
          end
        end
        bms_pkg::PH_START: begin
          n.countdown = cfg.interval;
          n.awaiting  = 1'b1;
          conv        = 1'b1;
          n.phase     = bms_pkg::PH_READ;
        end
        bms_pkg::PH_READ: begin
          n.measuring = 1'b0;
          n.armed     = interval_nz;
          if (!read_ok) begin
            n.bvalid = 1'b0;
            n.phase  = bms_pkg::PH_PRESENCE;
            ev_a     = bms_pkg::EV_ERROR;
          end else begin
            n.bmv    = v[14:0];
            n.bvalid = 1'b1;
            n.phase  = bms_pkg::PH_START;
            if (v[14:0] <= crit_mv) begin
              ev_a = bms_pkg::EV_CRITICAL;
              ev_b = bms_pkg::EV_UPDATE;
              two  = 1'b1;
            end else if (v[14:0] <= low_mv) begin
              ev_a = bms_pkg::EV_LOW;
              ev_b = bms_pkg::EV_UPDATE;
              two  = 1'b1;
            end else begin
              ev_a = bms_pkg::EV_UPDATE;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign st_nxt       = n;
  assign res.ev_a     = ev_a;
  assign res.ev_b     = ev_b;
  assign res.two      = two;
  assign res.conv     = conv;
  assign res.accepted = accepted;
  assign res.bmv      = n.bmv;
  assign res.bvalid   = n.bvalid;
  assign res.fmt      = n.fmt;
  assign res.awaiting = n.awaiting;

endmodule
`default_nettype wire

// ===== design/bms_pct.sv =====
`default_nettype none
module bms_pct (
  input  logic [14:0] mv,
  input  logic        mv_valid,
  input  logic [1:0]  fmt,
  output logic [6:0]  pct
);

  logic        mini;
  logic [14:0] base;
  logic        above;
  logic [14:0] diff;
  logic [30:0] prod;
  logic [11:0] quo;

  assign mini  = (fmt == bms_pkg::FMT_MINI);
  assign base  = mini ? bms_pkg::MINI_BASE_MV : bms_pkg::STD_BASE_MV;
  assign above = mv_valid && (mv > base);
  assign diff  = mv - base;
  // reciprocal of ten, exact for every 15-bit difference
  assign prod  = 31'(diff) * 31'(bms_pkg::PCT_RECIP);
  assign quo   = mini ? 12'(prod >> bms_pkg::PCT_SH_MINI) : 12'(prod >> bms_pkg::PCT_SH_STD);
  assign pct   = !above ? 7'd0 :
                 (quo > 12'(bms_pkg::CHARGE_MAX)) ? bms_pkg::CHARGE_MAX : quo[6:0];

endmodule
`default_nettype wire

// ===== design/battery_monitor_sequencer_core.sv =====
// channel | dir | handshake       | payload
// in_if   | in  | valid / ready   | opcode, present_pin, adc_millivolts, adc_ok
// out_if  | out | valid / ready   | event_code, voltage_mv, voltage_valid, charge_percent,
//         |     |                 | battery_format, start_conversion, sense_enable,
//         |     |                 | request_accepted, last
// cfg     | in  | cfg_we          | cfg_index, cfg_wdata
//
// one item accepted per cycle while in_if.ready is high; each item passes through in_r,
// res_b_r and c_r, and its result is offered on out_if from c_r
// an item with two events holds the output register for two result transfers
// sequencing and voltage conversion (one constant multiply) sit in one stage,
// the charge level (reciprocal multiply) in the next
// rst_n is synchronous, active low; clears the pipe, sequencer state and configuration registers
// out_if.ready low backs the pipe up; in_if.ready drops once all three stages are full
`default_nettype none
module battery_monitor_sequencer_core #(
  parameter int COEFF_FRACTION_BITS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  bms_in_if.sink           in_if,
  bms_out_if.source        out_if,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [31:0]      cfg_wdata
);

  // configuration registers
  bms_pkg::cfg_t   cfg_r;

  // sequencer state
  bms_pkg::state_t st_r;
  bms_pkg::state_t st_nxt;
  bms_pkg::state_t step_st;
  bms_pkg::res_t   step_res;

  // stage a: input register
  logic            a_valid_r;
  logic            a_valid_nxt;
  bms_pkg::item_t  in_r;

  // stage b: result of the sequencer step
  logic            b_valid_r;
  logic            b_valid_nxt;
  bms_pkg::res_t   res_b_r;

  // stage c: output register, sub_r picks the second event
  logic            c_valid_r;
  logic            c_valid_nxt;
  bms_pkg::out_t   c_r;
  logic            sub_r;
  logic [6:0]      pct;

  logic            in_xfer;
  logic            out_xfer;
  logic            c_last;
  logic            c_free;
  logic            b_adv;
  logic            b_free;
  logic            a_adv;
  logic            a_free;

  // pipeline control, back to front
  assign c_last   = !c_r.res.two || sub_r;
  assign out_xfer = out_if.valid && out_if.ready;
  assign c_free   = !c_valid_r || (out_xfer && c_last);
  assign b_adv    = b_valid_r && c_free;
  assign b_free   = !b_valid_r || c_free;
  assign a_adv    = a_valid_r && b_free;
  assign a_free   = !a_valid_r || b_free;
  assign in_if.ready = a_free;
  assign in_xfer  = in_if.valid && in_if.ready;

  assign a_valid_nxt = (a_valid_r && !a_adv) || in_xfer;
  assign b_valid_nxt = (b_valid_r && !b_adv) || a_adv;
  assign c_valid_nxt = (c_valid_r && !(out_xfer && c_last)) || b_adv;

  bms_step #(
    .COEFF_FRACTION_BITS(COEFF_FRACTION_BITS)
  ) u_step (
    .item   (in_r),
    .st     (st_r),
    .cfg    (cfg_r),
    .st_nxt (step_st),
    .res    (step_res)
  );

  bms_pct u_pct (
    .mv       (res_b_r.bmv),
    .mv_valid (res_b_r.bvalid),
    .fmt      (res_b_r.fmt),
    .pct      (pct)
  );

  // state moves on with each item; an interval write acts on it at once
  // (writes must only come while the pipe is empty; the block does not enforce this)
  always_comb begin
    st_nxt = a_adv ? step_st : st_r;
    if (cfg_we && cfg_index == bms_pkg::CFG_INTERVAL) begin
      if (cfg_wdata == 32'd0) begin
        if (!st_r.measuring) st_nxt.armed = 1'b0;
      end else if (!st_r.measuring) begin
        // behaves as a measure request run from the next tick
        st_nxt.measuring = 1'b1;
        if (!st_r.awaiting) begin
          st_nxt.countdown = 32'd0;
          st_nxt.armed     = 1'b1;
        end
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
      sub_r     <= 1'b0;
      st_r      <= bms_pkg::STATE_RESET;
      cfg_r     <= '0;
    end else begin
      a_valid_r <= a_valid_nxt;
      b_valid_r <= b_valid_nxt;
      c_valid_r <= c_valid_nxt;
      st_r      <= st_nxt;
      if (b_adv) begin
        sub_r <= 1'b0;
      end else if (out_xfer && !c_last) begin
        sub_r <= 1'b1;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          bms_pkg::CFG_INTERVAL: cfg_r.interval <= cfg_wdata;
          bms_pkg::CFG_OVERRIDE: cfg_r.override <= cfg_wdata[0];
          bms_pkg::CFG_LOW:      cfg_r.low_mv   <= cfg_wdata[14:0];
          bms_pkg::CFG_CRIT:     cfg_r.crit_mv  <= cfg_wdata[14:0];
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_r.opcode         <= in_if.opcode;
      in_r.present_pin    <= in_if.present_pin;
      in_r.adc_millivolts <= in_if.adc_millivolts;
      in_r.adc_ok         <= in_if.adc_ok;
    end
    if (a_adv) begin
      res_b_r <= step_res;
    end
    if (b_adv) begin
      c_r.res <= res_b_r;
      c_r.pct <= pct;
    end
  end

  // result channel: level event first, then update
  assign out_if.valid            = c_valid_r;
  assign out_if.event_code       = sub_r ? c_r.res.ev_b : c_r.res.ev_a;
  assign out_if.voltage_mv       = c_r.res.bmv;
  assign out_if.voltage_valid    = c_r.res.bvalid;
  assign out_if.charge_percent   = c_r.pct;
  assign out_if.battery_format   = c_r.res.fmt;
  assign out_if.start_conversion = c_r.res.conv && c_last;
  assign out_if.sense_enable     = c_r.res.awaiting;
  assign out_if.request_accepted = c_r.res.accepted;
  assign out_if.last             = c_last;

endmodule
`default_nettype wire

// ===== design/bms_checker.sv =====
`default_nettype none
module bms_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  event_code,
  input wire logic        voltage_valid,
  input wire logic [6:0]  charge_percent,
  input wire logic [1:0]  battery_format,
  input wire logic        start_conversion,
  input wire logic        last
);

  // stalled result keeps its event
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(event_code))
    else $error("result changed while stalled");

  // a conversion request only rides on the final result of an item
  a_conv_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && start_conversion |-> last)
    else $error("start_conversion on a non-final result");

  // no charge level without a valid voltage, and never above full
  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (voltage_valid || charge_percent == 7'd0) &&
                  charge_percent <= bms_pkg::CHARGE_MAX)
    else $error("charge level out of range");

  // level and update events come only from a good read of a known pack
  a_level_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (event_code == bms_pkg::EV_LOW || event_code == bms_pkg::EV_CRITICAL ||
                  event_code == bms_pkg::EV_UPDATE)
    |-> voltage_valid && battery_format != bms_pkg::FMT_UNKNOWN)
    else $error("level event without a valid reading");

endmodule

bind battery_monitor_sequencer_core bms_checker u_bms_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_if.valid),
  .out_ready        (out_if.ready),
  .event_code       (out_if.event_code),
  .voltage_valid    (out_if.voltage_valid),
  .charge_percent   (out_if.charge_percent),
  .battery_format   (out_if.battery_format),
  .start_conversion (out_if.start_conversion),
  .last             (out_if.last)
);
`default_nettype wire

// ===== dv/tb_battery_monitor_sequencer_core.sv =====
`default_nettype none
module tb_battery_monitor_sequencer_core;
  import bms_pkg::*;

  // opcode the block must treat as a no-op
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // q16 conversion coefficients, rounded to nearest from the exact ratios
  localparam int FRAC = 16;
  localparam longint unsigned GAIN_STD_Q  = ((64'd11068 << FRAC) + 64'd650) / 64'd1300;
  localparam longint unsigned OFS_STD_Q   = ((64'd212 << FRAC) + 64'd5) / 64'd10;
  localparam longint unsigned GAIN_MINI_Q = ((64'd3285 << FRAC) + 64'd500) / 64'd1000;
  localparam longint unsigned OFS_MINI_Q  = ((64'd69 << FRAC) + 64'd5) / 64'd10;
  localparam longint unsigned ROUND_Q     = 64'd1 << (FRAC - 1);

  // valid windows and charge level bases in millivolts
  localparam int unsigned STD_LO_MV   = 3800;
  localparam int unsigned STD_HI_MV   = 7000;
  localparam int unsigned MINI_LO_MV  = 1800;
  localparam int unsigned MINI_HI_MV  = 3800;
  localparam int unsigned STD_BASE    = 4000;
  localparam int unsigned MINI_BASE   = 2000;

  // run pacing
  localparam int QUIET_LIMIT  = 3000;  // cycles without any transfer before giving up
  localparam int HOLD_CYCLES  = 300;   // one long receiver hold-off
  localparam int DRAIN_CYCLES = 6;     // pipe depth plus margin after the last result

  typedef struct packed {
    logic [2:0]  ev;
    logic [14:0] mv;
    logic        vvalid;
    logic [6:0]  pct;
    logic [1:0]  fmt;
    logic        conv;
    logic        sense;
    logic        acc;
    logic        last;
  } monitor_report_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_wdata;

  bms_in_if  in_ch ();
  bms_out_if out_ch ();

  battery_monitor_sequencer_core #(
    .COEFF_FRACTION_BITS (FRAC)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  // expected results, oldest first
  monitor_report_t pending_reports[$];

  int  mismatches   = 0;
  int  items_sent   = 0;
  int  reports_seen = 0;
  int  reg_writes   = 0;
  int  quiet_cycles = 0;
  int  hold_epoch   = 0;  // bumped by a test to ask the receiver for one long hold-off
  bit  calm         = 1'b0;  // no random idling on either side while set

  // ---------------------------------------------------------------------------
  // sequencer shadow: registers and state as the block should hold them
  // ---------------------------------------------------------------------------
  logic [31:0] interval_ticks     = '0;
  logic        use_reg_thresholds = 1'b0;
  logic [14:0] low_mv_reg         = '0;
  logic [14:0] crit_mv_reg        = '0;

  phase_t      seq_phase      = PH_PRESENCE;
  logic [1:0]  pack_fmt       = FMT_UNKNOWN;
  bit          busy_measuring = 1'b0;
  logic [14:0] held_mv        = '0;
  bit          held_valid     = 1'b0;
  logic [31:0] tick_count     = '0;
  bit          timer_on       = 1'b0;
  bit          adc_pending    = 1'b0;

  // events raised by the item being predicted
  logic [2:0]  new_events [2];
  int          new_event_cnt;
  bit          conv_kicked;

  // battery millivolts from pin millivolts, rounding half up
  function automatic longint unsigned pack_mv(logic [11:0] adc, bit mini);
    longint unsigned gain, ofs;
    gain = mini ? GAIN_MINI_Q : GAIN_STD_Q;
    ofs  = mini ? OFS_MINI_Q : OFS_STD_Q;
    return (longint'(adc) * gain + ofs + ROUND_Q) >> FRAC;
  endfunction

  function automatic void queue_event(logic [2:0] code);
    if (new_event_cnt < 2) begin
      new_events[new_event_cnt] = code;
      new_event_cnt++;
    end
  endfunction

  // periodic timer only rearms while an interval is programmed
  function automatic void rearm();
    timer_on = (interval_ticks != 0);
  endfunction

  function automatic void kick_conversion(phase_t next);
    adc_pending = 1'b1;
    conv_kicked = 1'b1;
    seq_phase   = next;
  endfunction

  function automatic void advance_phases(logic present, logic [11:0] adc, logic ok);
    longint unsigned v, lo, hi;
    logic [14:0] low_t, crit_t;
    bit mini;
    // detection falls straight through to the read start while measuring
    if (seq_phase == PH_DETECT) begin
      v = pack_mv(adc, 1'b0);
      pack_fmt = (ok && v > STD_LO_MV && v < STD_HI_MV) ? FMT_STANDARD : FMT_MINI;
      seq_phase = PH_START;
      if (!busy_measuring) begin
        rearm();
        return;
      end
    end
    case (seq_phase)
      PH_PRESENCE: begin
        tick_count = interval_ticks;
        pack_fmt   = FMT_UNKNOWN;
        if (!present) begin
          rearm();
          if (interval_ticks == 0) busy_measuring = 1'b0;
          queue_event(EV_ERROR);
        end else begin
          kick_conversion(PH_DETECT);
        end
      end
      PH_START: begin
        tick_count = interval_ticks;
        kick_conversion(PH_READ);
      end
      PH_READ: begin
        mini = (pack_fmt == FMT_MINI);
        v  = pack_mv(adc, mini);
        lo = mini ? MINI_LO_MV : STD_LO_MV;
        hi = mini ? MINI_HI_MV : STD_HI_MV;
        busy_measuring = 1'b0;
        // a failed conversion counts as out of range
        if (!ok || v < lo || v > hi) begin
          held_valid = 1'b0;
          seq_phase  = PH_PRESENCE;
          rearm();
          queue_event(EV_ERROR);
        end else begin
          held_mv    = v[14:0];
          held_valid = 1'b1;
          if (use_reg_thresholds) begin
            low_t  = low_mv_reg;
            crit_t = crit_mv_reg;
          end else begin
            low_t  = mini ? 15'd2400 : 15'd4800;
            crit_t = mini ? 15'd2000 : 15'd4000;
          end
          if (held_mv <= crit_t) queue_event(EV_CRITICAL);
          else if (held_mv <= low_t) queue_event(EV_LOW);
          queue_event(EV_UPDATE);
          seq_phase = PH_START;
          rearm();
        end
      end
      default: ;
    endcase
  endfunction

  function automatic logic [6:0] charge_level_of();
    int unsigned base, span, p;
    base = (pack_fmt == FMT_MINI) ? MINI_BASE : STD_BASE;
    span = (pack_fmt == FMT_MINI) ? 10 : 20;
    if (!held_valid || held_mv <= base) return 7'd0;
    p = (held_mv - base) / span;
    return (p > 100) ? 7'd100 : p[6:0];
  endfunction

  // one accepted input: update the shadow and queue the results it causes
  function automatic void predict_reports(logic [1:0] op, logic present, logic [11:0] adc,
                                          logic ok);
    bit accepted;
    int n;
    logic [6:0] pct;
    monitor_report_t r;
    accepted      = 1'b0;
    new_event_cnt = 0;
    conv_kicked   = 1'b0;
    case (op)
      OP_TICK: begin
        if (tick_count != 0) tick_count = tick_count - 32'd1;
        if (timer_on && tick_count == 0) begin
          timer_on = 1'b0;
          advance_phases(present, adc, ok);
        end
      end
      OP_REQUEST: begin
        // refused while a measurement is already running
        if (!busy_measuring) begin
          busy_measuring = 1'b1;
          accepted       = 1'b1;
          // a conversion in flight serves the request
          if (!adc_pending) begin
            timer_on = 1'b0;
            advance_phases(present, adc, ok);
          end
        end
      end
      OP_DONE: begin
        // stray completions are dropped
        if (adc_pending) begin
          adc_pending = 1'b0;
          advance_phases(present, adc, ok);
        end
      end
      default: ;
    endcase
    pct = charge_level_of();
    n = (new_event_cnt > 0) ? new_event_cnt : 1;
    for (int k = 0; k < n; k++) begin
      r.ev     = (k < new_event_cnt) ? new_events[k] : EV_NONE;
      r.mv     = held_mv;
      r.vvalid = held_valid;
      r.pct    = pct;
      r.fmt    = pack_fmt;
      r.last   = (k == n - 1);
      r.conv   = conv_kicked && r.last;
      r.sense  = adc_pending;
      r.acc    = accepted;
      pending_reports.push_back(r);
    end
  endfunction

  function automatic void apply_register(logic [1:0] idx, logic [31:0] val);
    case (idx)
      CFG_INTERVAL: begin
        interval_ticks = val;
        // a nonzero interval acts like a request that fires on the next tick
        if (val == 0) begin
          if (!busy_measuring) timer_on = 1'b0;
        end else if (!busy_measuring) begin
          busy_measuring = 1'b1;
          if (!adc_pending) begin
            tick_count = '0;
            timer_on   = 1'b1;
          end
        end
      end
      CFG_OVERRIDE: use_reg_thresholds = val[0];
      CFG_LOW:      low_mv_reg  = val[14:0];
      CFG_CRIT:     crit_mv_reg = val[14:0];
      default: ;
    endcase
  endfunction

  function automatic string report_text(monitor_report_t r);
    return $sformatf("ev=%0d mv=%0d vv=%0b pct=%0d fmt=%0d conv=%0b sense=%0b acc=%0b last=%0b",
                     r.ev, r.mv, r.vvalid, r.pct, r.fmt, r.conv, r.sense, r.acc, r.last);
  endfunction

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------

  // offer one item after a random gap, return at the edge of its transfer
  task automatic send_item(logic [1:0] op, logic present, logic [11:0] adc, logic ok);
    int gap;
    gap = 0;
    if (!calm) begin
      while ($urandom_range(0, 99) < 32) gap++;
    end
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.opcode         <= op;
    in_ch.present_pin    <= present;
    in_ch.adc_millivolts <= adc;
    in_ch.adc_ok         <= ok;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_reports(op, present, adc, ok);
    items_sent++;
  endtask

  // item picked from the shadow state so most traffic follows real sequences
  task automatic send_random_item(int tick_pct);
    int r;
    logic [1:0]  op;
    logic        present;
    logic [11:0] adc;
    logic        ok;
    present = ($urandom_range(0, 9) != 0);
    ok      = ($urandom_range(0, 9) != 0);
    // mostly around the valid windows and thresholds, sometimes anywhere
    adc = ($urandom_range(0, 9) < 7) ? 12'($urandom_range(400, 1200))
                                     : 12'($urandom_range(0, 4095));
    r = $urandom_range(0, 99);
    if (adc_pending && r < 60) begin
      op = OP_DONE;
    end else begin
      r = $urandom_range(0, 99);
      if (r < tick_pct) op = OP_TICK;
      else if (r < 90) op = OP_REQUEST;
      else if (r < 97) op = OP_DONE;
      else op = OP_UNUSED;
    end
    send_item(op, present, adc, ok);
  endtask

  // request, then answer every conversion the sequencer asks for
  task automatic run_measurement(logic [11:0] detect_adc, logic [11:0] read_adc);
    send_item(OP_REQUEST, 1'b1, 12'($urandom), 1'b1);
    while (adc_pending)
      send_item(OP_DONE, 1'b1, (seq_phase == PH_DETECT) ? detect_adc : read_adc, 1'b1);
  endtask

  // stop offering and let every expected result come out
  task automatic settle_block();
    in_ch.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(logic [1:0] idx, logic [31:0] val);
    settle_block();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    apply_register(idx, val);
    cfg_we <= 1'b0;
    reg_writes++;
  endtask

  task automatic write_random_register();
    logic [1:0]  idx;
    logic [31:0] val;
    idx = 2'($urandom_range(0, 3));
    case (idx)
      CFG_INTERVAL: begin
        case ($urandom_range(0, 4))
          0:       val = 32'd0;
          1:       val = 32'hFFFF_FFFF;
          2:       val = $urandom;
          default: val = $urandom_range(1, 6);
        endcase
      end
      CFG_OVERRIDE: val = $urandom_range(0, 1);
      default: begin
        case ($urandom_range(0, 3))
          0:       val = 32'd0;
          1:       val = 32'h0000_7FFF;
          2:       val = $urandom_range(1800, 7000);
          default: val = $urandom;
        endcase
      end
    endcase
    write_register(idx, val);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // corner cases with reset settings: no interval, default thresholds
  task automatic test_directed();
    send_item(OP_TICK,    1'b1, 12'd0,    1'b1);  // timer not armed
    send_item(OP_UNUSED,  1'b1, 12'hFFF,  1'b1);  // unused opcode
    send_item(OP_DONE,    1'b1, 12'd600,  1'b1);  // stray completion
    send_item(OP_REQUEST, 1'b0, 12'd0,    1'b0);  // no battery
    send_item(OP_REQUEST, 1'b1, 12'd0,    1'b1);  // presence ok, detect conversion
    send_item(OP_REQUEST, 1'b1, 12'd0,    1'b1);  // busy, refused
    send_item(OP_DONE,    1'b1, 12'd600,  1'b1);  // standard pack
    send_item(OP_DONE,    1'b1, 12'd444,  1'b1);  // just above the window floor, critical
    send_item(OP_REQUEST, 1'b1, 12'd0,    1'b1);
    send_item(OP_DONE,    1'b1, 12'd820,  1'b1);  // just above the window top
    send_item(OP_REQUEST, 1'b1, 12'd0,    1'b1);
    send_item(OP_DONE,    1'b1, 12'hFFF,  1'b0);  // failed detection, mini
    send_item(OP_DONE,    1'b1, 12'd1154, 1'b1);  // mini near top of window
    send_item(OP_REQUEST, 1'b1, 12'd0,    1'b1);
    send_item(OP_DONE,    1'b1, 12'd0,    1'b1);  // far below window
    send_item(OP_REQUEST, 1'b1, 12'd0,    1'b1);
    send_item(OP_DONE,    1'b1, 12'hFFF,  1'b1);  // overrange detection, mini
    send_item(OP_DONE,    1'b1, 12'd900,  1'b0);  // failed read, error
    send_item(OP_REQUEST, 1'b1, 12'd0,    1'b1);
    send_item(OP_DONE,    1'b1, 12'd700,  1'b1);
    send_item(OP_DONE,    1'b1, 12'd540,  1'b1);  // standard low level
    send_item(OP_REQUEST, 1'b1, 12'd0,    1'b1);
    send_item(OP_DONE,    1'b1, 12'hFFF,  1'b1);  // overrange read
    send_item(OP_TICK,    1'b0, 12'hFFF,  1'b0);
  endtask

  // register thresholds at their extremes
  task automatic test_threshold_override();
    write_register(CFG_OVERRIDE, 32'd1);
    write_register(CFG_LOW, 32'h0000_7FFF);
    write_register(CFG_CRIT, 32'd0);
    run_measurement(12'd600, 12'd700);
    run_measurement(12'd1000, 12'd900);
    write_register(CFG_CRIT, 32'h0000_7FFF);
    run_measurement(12'd600, 12'd500);
    write_register(CFG_LOW, 32'd0);
    write_register(CFG_CRIT, 32'd0);
    run_measurement(12'd600, 12'd780);
    run_measurement(12'd1200, 12'd560);
    write_register(CFG_OVERRIDE, 32'd0);
  endtask

  // timer driven measurement over short, longest and no interval
  task automatic test_periodic_ticks();
    logic [31:0] periods [4];
    periods = '{32'd1, 32'd3, 32'hFFFF_FFFF, 32'd0};
    foreach (periods[i]) begin
      write_register(CFG_INTERVAL, periods[i]);
      repeat (25) send_random_item(70);
    end
  endtask

  task automatic test_random_traffic();
    for (int n = 0; n < 200; n++) begin
      if (n % 40 == 0) write_random_register();
      send_random_item(30);
    end
  endtask

  // back to back transfers on both sides
  task automatic test_steady_stream();
    calm = 1'b1;
    repeat (60) send_random_item(30);
    calm = 1'b0;
  endtask

  // receiver holds off while items keep coming, so the pipe fills and stalls
  task automatic test_receiver_hold();
    calm = 1'b1;
    hold_epoch++;
    repeat (40) send_random_item(30);
    calm = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // output side
  // ---------------------------------------------------------------------------

  // result ready: random idling, one long hold-off on request
  initial begin : receiver_pacing
    int hold_left;
    int epoch_seen;
    hold_left  = 0;
    epoch_seen = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (epoch_seen != hold_epoch) begin
        epoch_seen = hold_epoch;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (calm) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= 32);
      end
    end
  end

  // compare every result transfer with the oldest expectation
  always @(posedge clk) begin : result_check
    monitor_report_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.ev     = out_ch.event_code;
      got.mv     = out_ch.voltage_mv;
      got.vvalid = out_ch.voltage_valid;
      got.pct    = out_ch.charge_percent;
      got.fmt    = out_ch.battery_format;
      got.conv   = out_ch.start_conversion;
      got.sense  = out_ch.sense_enable;
      got.acc    = out_ch.request_accepted;
      got.last   = out_ch.last;
      if (pending_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with nothing expected: %s", $time, report_text(got));
      end else begin
        want = pending_reports.pop_front();
        reports_seen++;
        if (got.ev !== want.ev || got.mv !== want.mv || got.vvalid !== want.vvalid ||
            got.pct !== want.pct || got.fmt !== want.fmt || got.conv !== want.conv ||
            got.sense !== want.sense || got.acc !== want.acc || got.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: mismatch expected %s actual %s", $time, report_text(want),
                     report_text(got));
        end
      end
    end
  end

  // give up when neither channel moves for too long
  always @(posedge clk) begin : watchdog
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
               quiet_cycles, pending_reports.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n                <= 1'b0;
    cfg_we               <= 1'b0;
    cfg_index            <= CFG_INTERVAL;
    cfg_wdata            <= '0;
    in_ch.valid          <= 1'b0;
    in_ch.opcode         <= OP_TICK;
    in_ch.present_pin    <= 1'b0;
    in_ch.adc_millivolts <= '0;
    in_ch.adc_ok         <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_threshold_override();
    test_periodic_ticks();
    test_random_traffic();
    test_steady_stream();
    test_receiver_hold();

    settle_block();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered presence, detection, read and timer paths over %0d items and %0d results",
             items_sent, reports_seen);
    $display("with %0d register writes, random idling and one %0d cycle receiver hold-off",
             reg_writes, HOLD_CYCLES);
    if (mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
`default_nettype wire
